// ===== hdl/gpwg_pkg.sv =====
// gpwg_pkg: shared types and constants of the gaussian payload word generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gpwg_pkg;
    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_ADD     = 32'd1013904223;
    localparam logic [31:0] SEED_RESET  = 32'h0000ABCD;
    localparam logic [15:0] MEAN_RESET  = 16'h1FFF;
    localparam logic [15:0] SPREAD_RESET = 16'h07FF;
    localparam logic [33:0] TWO_LN2_Q30 = 34'h58B90BFC;
    localparam logic [33:0] HALF_PI_Q31 = 34'hC90FDAA2;
    localparam logic [31:0] ONE_Q30     = 32'h40000000;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_MEAN   = 2'd1;
    localparam logic [1:0] REG_SPREAD = 2'd2;

    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] mean;
        logic [15:0] spread;
    } cfg_t;

    // divisors of the cosine series, one per step
    function automatic logic [7:0] cos_div(input logic [2:0] k);
        logic [7:0] d;
        begin
            unique case (k)
                3'd0: d = 8'd132;
                3'd1: d = 8'd90;
                3'd2: d = 8'd56;
                3'd3: d = 8'd30;
                3'd4: d = 8'd12;
                default: d = 8'd2;
            endcase
            return d;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hdl/gpwg_if.sv =====
// gpwg_if: valid/ready channel interfaces for requests, results and config
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface gpwg_req_if;
    logic valid;
    logic ready;
    logic emit_index;
    logic last_in;
    modport source (output valid, output emit_index, output last_in, input ready);
    modport sink (input valid, input emit_index, input last_in, output ready);
endinterface

interface gpwg_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        last_out;
    modport source (output valid, output word, output last_out, input ready);
    modport sink (input valid, input word, input last_out, output ready);
endinterface

interface gpwg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/gpwg_mul.sv =====
// gpwg_mul: shift-add multiplier, 2 bits of operand b per cycle
// no package use
`timescale 1ns / 1ps
`default_nettype none
module gpwg_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [33:0] a,
    input  wire logic [33:0] b,
    output logic             done,
    output logic [67:0]      prod
);
    logic [67:0] acc_reg, acc_next;
    logic [67:0] ash_reg, ash_next;
    logic [33:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            ash_next  = {34'd0, a};
            b_next    = b;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one radix-4 digit of b
            acc_next = acc_reg + (b_reg[0] ? ash_reg : 68'd0)
                       + (b_reg[1] ? {ash_reg[66:0], 1'b0} : 68'd0);
            ash_next = {ash_reg[65:0], 2'b00};
            b_next   = {2'b00, b_reg[33:2]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== hdl/gpwg_div.sv =====
// gpwg_div: restoring divider, one quotient bit per cycle, 32-bit dividend
// no package use
`timescale 1ns / 1ps
`default_nettype none
module gpwg_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [7:0]  den,
    output logic             done,
    output logic [31:0]      quo
);
    logic [31:0] q_reg, q_next;
    logic [8:0]  r_reg, r_next;
    logic [7:0]  d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[7:0], q_reg[31]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

// ===== hdl/gpwg_sqrt.sv =====
// gpwg_sqrt: bit-pair integer square root of a 48-bit value, one result bit per cycle
// no package use
`timescale 1ns / 1ps
`default_nettype none
module gpwg_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] val,
    output logic             done,
    output logic [23:0]      root
);
    logic [47:0] v_reg, v_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] trial;
    logic [25:0] sub;

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[23:0], v_reg[47:46]};
        sub       = {q_reg, 2'b01};
        if (start)
        begin
            v_next    = val;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = {v_reg[45:0], 2'b00};
            if (trial >= sub)
            begin
                rem_next = trial - sub;
                q_next   = {q_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign root = q_reg;
endmodule
`default_nettype wire

// ===== hdl/gaussian_payload_word_generator_top.sv =====
// gaussian_payload_word_generator_top: request sequencer, state and output register
// depends on gpwg_pkg, gpwg_if, gpwg_mul, gpwg_div, gpwg_sqrt
`timescale 1ns / 1ps
`default_nettype none
// One request in, one 16-bit payload word out. An index request returns the
// position counter through the output register. A sample request is sequenced
// over serial units: a shared radix-4 shift-add multiplier (37 products
// including 24 log squarings and the cosine series), a bit-serial divider
// (5 series steps) and a bit-pair square root, so the time a sample takes is
// set mostly by the multiplier. One request is in work at a time; a finished
// word waits in the output register and the next request is taken once it
// has gone. Config writes are accepted at any time and should be made while
// idle. No clearing pass after reset.
module gaussian_payload_word_generator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    gpwg_req_if.sink   req,
    gpwg_res_if.source res,
    gpwg_cfg_if.sink   cfg
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LCG1  = 14'b00000000000010,
        S_LCG2  = 14'b00000000000100,
        S_NORM  = 14'b00000000001000,
        S_SQR   = 14'b00000000010000,
        S_LNMUL = 14'b00000000100000,
        S_SQRT  = 14'b00000001000000,
        S_ANG   = 14'b00000010000000,
        S_X     = 14'b00000100000000,
        S_HMUL  = 14'b00001000000000,
        S_HDIV  = 14'b00010000000000,
        S_PM1   = 14'b00100000000000,
        S_PM2   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    gpwg_pkg::cfg_t cfg_reg, cfg_next;
    logic [31:0] lcg_reg, lcg_next;
    logic [15:0] pos_reg, pos_next;
    logic [31:0] u1_reg, u1_next;
    logic [31:0] u2_reg, u2_next;
    logic [33:0] m_reg, m_next;        // log mantissa, then general operand
    logic [31:0] lg_reg, lg_next;      // log2, then -2 ln u1
    logic [4:0]  n_reg, n_next;        // leading one position
    logic [23:0] r_reg, r_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] h_reg, h_next;
    logic [2:0]  k_reg, k_next;
    logic        neg_reg, neg_next;
    logic [16:0] c_reg, c_next;
    logic [33:0] p_reg, p_next;
    logic [15:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        ovalid_reg, ovalid_next;
    logic        go_reg, go_next;      // a unit start has been issued

    logic        mul_start, mul_done;
    logic [33:0] mul_a, mul_b;
    logic [67:0] mul_p;
    logic        div_start, div_done;
    logic [31:0] div_num, div_q;
    logic        sq_start, sq_done;
    logic [47:0] sq_val;
    logic [23:0] sq_root;

    logic [31:0] u1f;
    logic [5:0]  lz;
    logic [33:0] hx;
    logic [31:0] cq;
    logic [32:0] cr;
    logic [56:0] tsum;
    logic [16:0] termi;
    logic [17:0] s18;

    gpwg_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                    .done(mul_done), .prod(mul_p));
    gpwg_div u_div (.clk, .rst_n, .start(div_start), .num(div_num),
                    .den(gpwg_pkg::cos_div(k_reg)), .done(div_done), .quo(div_q));
    gpwg_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .val(sq_val),
                      .done(sq_done), .root(sq_root));

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg.ready = 1'b1;
    assign res.valid = ovalid_reg;
    assign res.word = word_reg;
    assign res.last_out = last_reg;

    // leading one of u1, searched over a 32-bit priority chain
    always_comb
    begin
        u1f = (u1_reg == 32'd0) ? 32'd1 : u1_reg;
        lz  = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (u1f[i])
            begin
                lz = 6'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cfg_next    = cfg_reg;
        lcg_next    = lcg_reg;
        pos_next    = pos_reg;
        u1_next     = u1_reg;
        u2_next     = u2_reg;
        m_next      = m_reg;
        lg_next     = lg_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        x_next      = x_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        neg_next    = neg_reg;
        c_next      = c_reg;
        p_next      = p_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        go_next     = go_reg;
        mul_start   = 1'b0;
        mul_a       = m_reg;
        mul_b       = m_reg;
        div_start   = 1'b0;
        div_num     = mul_p[61:30];
        sq_start    = 1'b0;
        sq_val      = {r_reg, 24'd0};
        hx          = '0;
        cq          = '0;
        cr          = '0;
        tsum        = '0;
        termi       = '0;
        s18         = '0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                gpwg_pkg::REG_SEED:   cfg_next.seed = cfg.data;
                gpwg_pkg::REG_MEAN:   cfg_next.mean = cfg.data[15:0];
                gpwg_pkg::REG_SPREAD: cfg_next.spread = cfg.data[15:0];
                default: ;
            endcase
        end
        if (res.ready && ovalid_reg)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    last_next = req.last_in;
                    if (req.emit_index)
                    begin
                        word_next   = pos_reg;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        if (pos_reg == 16'd0)
                        begin
                            lcg_next = cfg_reg.seed;
                        end
                        pos_next   = pos_reg + 16'd2;
                        state_next = S_LCG1;
                    end
                end
            end
            S_LCG1:
            begin
                // low 32 bits of one product and sum per draw
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = {2'b00, lcg_reg};
                    mul_b = {2'b00, gpwg_pkg::LCG_MUL};
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    lcg_next = mul_p[31:0] + gpwg_pkg::LCG_ADD;
                    u1_next = mul_p[31:0] + gpwg_pkg::LCG_ADD;
                    go_next = 1'b0;
                    state_next = S_LCG2;
                end
            end
            S_LCG2:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = {2'b00, lcg_reg};
                    mul_b = {2'b00, gpwg_pkg::LCG_MUL};
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    lcg_next = mul_p[31:0] + gpwg_pkg::LCG_ADD;
                    u2_next = mul_p[31:0] + gpwg_pkg::LCG_ADD;
                    go_next = 1'b0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                m_next  = {2'b00, u1f << (5'd31 - lz[4:0])};
                lg_next = '0;
                n_next  = lz[4:0];
                k_next  = '0;
                x_next  = '0;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                // one fraction bit of log2 per squaring
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    if (mul_p[63])
                    begin
                        m_next  = {2'b00, mul_p[63:32]};
                        lg_next = {lg_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        m_next  = {1'b0, mul_p[63:31]};
                        lg_next = {lg_reg[30:0], 1'b0};
                    end
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'd7)
                    begin
                        n_next = n_reg;
                    end
                    if (lg_reg[31:24] == 8'd0 && {m_reg[33:32]} == 2'b00 && x_reg[4:0] == 5'd23)
                    begin
                        lg_next[31:24] = {3'd0, n_reg};
                        x_next  = '0;
                        state_next = S_LNMUL;
                    end
                    else
                    begin
                        x_next = x_reg + 32'd1;
                    end
                end
            end
            S_LNMUL:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = {2'b00, 32'h20000000 - lg_reg};
                    mul_b = gpwg_pkg::TWO_LN2_Q30;
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    // -2 ln u1 in Q8.24, below 2^30
                    lg_next = mul_p[61:30];
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (!go_reg)
                begin
                    sq_start = 1'b1;
                    sq_val = {lg_reg, 16'd0};
                    go_next = 1'b1;
                end
                else if (sq_done)
                begin
                    go_next = 1'b0;
                    r_next = sq_root;
                    neg_next = u2_reg[31] ^ u2_reg[30];
                    state_next = S_ANG;
                end
            end
            S_ANG:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = u2_reg[30] ? {3'd0, 31'h40000000 - {1'b0, u2_reg[29:0]}}
                                       : {4'd0, u2_reg[29:0]};
                    mul_b = gpwg_pkg::HALF_PI_Q31;
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    m_next = {2'b00, mul_p[62:31]};
                    state_next = S_X;
                end
            end
            S_X:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    x_next = mul_p[61:30];
                    h_next = gpwg_pkg::ONE_Q30;
                    k_next = '0;
                    state_next = S_HMUL;
                end
            end
            S_HMUL:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = {2'b00, x_reg};
                    mul_b = {2'b00, h_reg};
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    if (k_reg == 3'd5)
                    begin
                        // final step halves the product
                        hx = {2'b00, mul_p[61:30]};
                        cq = hx[32:1];
                        cr = {1'b0, gpwg_pkg::ONE_Q30} - {1'b0, cq};
                        if (cr[32])
                        begin
                            c_next = 17'd0;
                        end
                        else if (cr[31:0] > gpwg_pkg::ONE_Q30)
                        begin
                            c_next = 17'd65536;
                        end
                        else
                        begin
                            c_next = 17'((cr[31:0] + 32'd8192) >> 14);
                        end
                        state_next = S_PM1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        state_next = S_HDIV;
                        go_next = 1'b1;
                    end
                end
            end
            S_HDIV:
            begin
                if (div_done)
                begin
                    go_next = 1'b0;
                    h_next = gpwg_pkg::ONE_Q30 - div_q;
                    k_next = k_reg + 3'd1;
                    state_next = S_HMUL;
                end
            end
            S_PM1:
            begin
                // spread times cosine magnitude, below 2^32
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = {18'd0, cfg_reg.spread};
                    mul_b = {17'd0, c_reg};
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    p_next = mul_p[33:0];
                    state_next = S_PM2;
                end
            end
            S_PM2:
            begin
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    mul_a = p_reg;
                    mul_b = {10'd0, r_reg};
                    go_next = 1'b1;
                end
                else if (mul_done)
                begin
                    go_next = 1'b0;
                    // magnitude below 2^55, rounded away from zero when negative
                    tsum = mul_p[56:0];
                    if (neg_reg)
                    begin
                        tsum = tsum + 57'h0_000F_FFFF_FFFF;
                    end
                    termi = (tsum[56:53] != 4'd0) ? 17'h1FFFF : tsum[52:36];
                    if (neg_reg)
                    begin
                        s18 = {2'b00, cfg_reg.mean} - {1'b0, termi};
                        word_next = s18[17] ? 16'd0 : s18[15:0];
                    end
                    else
                    begin
                        s18 = {2'b00, cfg_reg.mean} + {1'b0, termi};
                        word_next = (s18[17:16] != 2'b00) ? 16'hFFFF : s18[15:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cfg_reg    <= '{seed: gpwg_pkg::SEED_RESET, mean: gpwg_pkg::MEAN_RESET,
                            spread: gpwg_pkg::SPREAD_RESET};
            lcg_reg    <= gpwg_pkg::SEED_RESET;
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
            go_reg     <= 1'b0;
            x_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            lcg_reg    <= lcg_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
            go_reg     <= go_next;
            x_reg      <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u1_reg   <= u1_next;
        u2_reg   <= u2_next;
        m_reg    <= m_next;
        lg_reg   <= lg_next;
        n_reg    <= n_next;
        r_reg    <= r_next;
        h_reg    <= h_next;
        k_reg    <= k_next;
        neg_reg  <= neg_next;
        c_reg    <= c_next;
        p_reg    <= p_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench for gaussian_payload_word_generator_top
// depends on gpwg_pkg, gpwg_if and the rtl of the block
`timescale 1ns / 1ps
`default_nettype none
module tb;
    // index that maps to no register, writes to it must be ignored
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct packed {
        logic [15:0] word;
        logic        last_out;
    } word_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gpwg_req_if req_ch ();
    gpwg_res_if res_ch ();
    gpwg_cfg_if cfg_ch ();

    gaussian_payload_word_generator_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // predictor copy of registers and state
    gpwg_pkg::cfg_t model_cfg;
    logic [31:0]    model_lcg;
    logic [15:0]    model_pos;

    word_exp_t expected_words[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.emit_index = 1'b0;
        req_ch.last_in = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = gpwg_pkg::REG_SEED;
        cfg_ch.data = '0;
    end

    // -2 ln(x / 2^32) in Q8.24 by leading-one and repeated squaring
    function automatic logic [63:0] neg_two_ln(input logic [31:0] x);
        int          lead;
        logic [63:0] mant;
        logic [63:0] lg;
        logic [63:0] diff;
        lead = 31;
        while (lead > 0 && !x[lead])
            lead--;
        mant = 64'(x) << (31 - lead);
        lg = '0;
        for (int k = 0; k < 24; k++)
        begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000)
            begin
                mant = mant >> 1;
                lg = (lg << 1) | 64'd1;
            end
            else
                lg = lg << 1;
        end
        lg = lg | (64'(lead) << 24);
        diff = (64'd32 << 24) - lg;
        return (diff * 64'(gpwg_pkg::TWO_LN2_Q30)) >> 30;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // cosine of a quarter-turn fraction, Q1.16 in 0..65536
    function automatic longint quarter_cos(input logic [63:0] f);
        longint      divisors[5] = '{132, 90, 56, 30, 12};
        logic [63:0] ang;
        logic [63:0] sq;
        longint      h;
        longint      c;
        ang = (f * 64'(gpwg_pkg::HALF_PI_Q31)) >> 31;
        sq = (ang * ang) >> 30;
        h = longint'(gpwg_pkg::ONE_Q30);
        for (int k = 0; k < 5; k++)
            h = longint'(gpwg_pkg::ONE_Q30)
                - longint'(((sq * 64'(h)) >> 30) / 64'(divisors[k]));
        c = longint'(gpwg_pkg::ONE_Q30) - longint'(((sq * 64'(h)) >> 30) / 64'd2);
        if (c < 0)
            c = 0;
        if (c > longint'(gpwg_pkg::ONE_Q30))
            c = longint'(gpwg_pkg::ONE_Q30);
        return (c + 8192) >>> 14;
    endfunction

    function automatic longint turn_cos(input logic [31:0] y);
        logic [63:0] f;
        f = 64'(y[29:0]);
        unique case (y[31:30])
            2'd0: return quarter_cos(f);
            2'd1: return -quarter_cos((64'd1 << 30) - f);
            2'd2: return -quarter_cos(f);
            default: return quarter_cos((64'd1 << 30) - f);
        endcase
    endfunction

    // advances predictor state by one sample request
    function automatic logic [15:0] next_gaussian_word();
        logic [31:0] u1;
        logic [31:0] u2;
        logic [63:0] radius;
        logic [63:0] mag;
        longint      c;
        longint      term;
        longint      sum;
        if (model_pos == 16'd0)
            model_lcg = model_cfg.seed;
        model_pos = model_pos + 16'd2;
        model_lcg = model_lcg * gpwg_pkg::LCG_MUL + gpwg_pkg::LCG_ADD;
        u1 = model_lcg;
        model_lcg = model_lcg * gpwg_pkg::LCG_MUL + gpwg_pkg::LCG_ADD;
        u2 = model_lcg;
        if (u1 == 32'd0)
            u1 = 32'd1;
        radius = int_sqrt(neg_two_ln(u1) << 16);
        c = turn_cos(u2);
        mag = 64'(model_cfg.spread) * radius * 64'(c < 0 ? -c : c);
        if (c < 0)
            term = -longint'((mag + ((64'd1 << 36) - 64'd1)) >> 36);
        else
            term = longint'(mag >> 36);
        sum = longint'(model_cfg.mean) + term;
        if (sum < 0)
            sum = 0;
        if (sum > 65535)
            sum = 65535;
        return sum[15:0];
    endfunction

    // receiver side: random stalls on the result channel
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);

    // result checker, compares against the oldest pending word
    always @(posedge clk)
    begin
        word_exp_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: unexpected item word=%h last=%b",
                             res_ch.word, res_ch.last_out);
            end
            else
            begin
                want = expected_words.pop_front();
                if (res_ch.word !== want.word || res_ch.last_out !== want.last_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: word exp %h got %h, last exp %b got %b",
                                 want.word, res_ch.word, want.last_out, res_ch.last_out);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("FAIL gaussian_payload_word_generator_top");
            $finish;
        end
    end

    // one register write, made only while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        unique case (idx)
            gpwg_pkg::REG_SEED:   model_cfg.seed = value;
            gpwg_pkg::REG_MEAN:   model_cfg.mean = value[15:0];
            gpwg_pkg::REG_SPREAD: model_cfg.spread = value[15:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // one request item; valid stays high into the next item unless a gap is drawn
    task automatic send_request(input logic emit_index, input logic last_in);
        word_exp_t want;
        if (req_ch.valid && $urandom_range(99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.emit_index <= emit_index;
        req_ch.last_in <= last_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        want.word = emit_index ? model_pos : next_gaussian_word();
        want.last_out = last_in;
        expected_words.push_back(want);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        // block may still settle its output register
        repeat (4) @(posedge clk);
    endtask

    // seed whose first generator draw is zero, built from the inverse of the multiplier
    function automatic logic [31:0] zero_draw_seed();
        logic [31:0] inv;
        inv = gpwg_pkg::LCG_MUL;
        repeat (5)
            inv = inv * (32'd2 - gpwg_pkg::LCG_MUL * inv);
        return (32'd0 - gpwg_pkg::LCG_ADD) * inv;
    endfunction

    // first sample after reset reloads the seed; pick one that makes u1 zero
    task automatic test_zero_uniform();
        write_reg(gpwg_pkg::REG_SEED, zero_draw_seed());
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b1);
        drain();
    endtask

    // index requests leave state alone; clamp at both ends; zero spread
    task automatic test_directed();
        send_request(1'b1, 1'b0);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b1);
        drain();
        write_reg(gpwg_pkg::REG_MEAN, 32'h0000_0000);
        write_reg(gpwg_pkg::REG_SPREAD, 32'hFFFF_FFFF);
        write_reg(gpwg_pkg::REG_SEED, 32'hFFFF_FFFF);
        repeat (5)
            send_request(1'b0, 1'b1);
        drain();
        write_reg(gpwg_pkg::REG_MEAN, 32'h0001_FFFF);
        write_reg(gpwg_pkg::REG_SEED, 32'h0000_0000);
        repeat (5)
            send_request(1'b0, 1'b0);
        drain();
        write_reg(gpwg_pkg::REG_SPREAD, 32'h0000_0000);
        write_reg(gpwg_pkg::REG_MEAN, 32'h0000_1234);
        send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);
        drain();
    endtask

    // random mix of requests under one idle pattern; config drawn at the start and changed between bursts
    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        write_reg(gpwg_pkg::REG_SEED, $urandom());
        write_reg(gpwg_pkg::REG_MEAN, $urandom_range(65535));
        write_reg(gpwg_pkg::REG_SPREAD, $urandom_range(65535));
        for (int i = 0; i < count; i++)
        begin
            // occasional config change between bursts
            if (i % 100 == 99)
            begin
                drain();
                write_reg(gpwg_pkg::REG_MEAN,
                          $urandom_range(3) == 0 ? 32'd0 : $urandom_range(65535));
                write_reg(gpwg_pkg::REG_SPREAD,
                          $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(65535));
            end
            send_request($urandom_range(99) < 45, $urandom_range(1));
        end
        drain();
    endtask

    initial
    begin
        model_cfg.seed = gpwg_pkg::SEED_RESET;
        model_cfg.mean = gpwg_pkg::MEAN_RESET;
        model_cfg.spread = gpwg_pkg::SPREAD_RESET;
        model_lcg = gpwg_pkg::SEED_RESET;
        model_pos = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_uniform();
        test_directed();
        test_random(500, 23, 84);
        test_random(500, 84, 23);
        test_random(500, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS gaussian_payload_word_generator_top");
        else
            $display("FAIL gaussian_payload_word_generator_top");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/gpwg_pkg.sv
hdl/gpwg_if.sv
hdl/gpwg_mul.sv
hdl/gpwg_div.sv
hdl/gpwg_sqrt.sv
hdl/gaussian_payload_word_generator_top.sv
dv/tb.sv
